[rtl/refcounted_block_allocator_core_macros.svh]
// Assertion helpers for the allocator RTL
`ifndef REFCOUNTED_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define REFCOUNTED_BLOCK_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RBA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rba assertion failed");
`define RBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rba assertion failed");
`else
`define RBA_ASSERT_IMP(label, clk, rst, ante, cons)
`define RBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/rba_pkg.sv]
package rba_pkg;

  localparam int TOTAL_BLOCKS   = 64;
  localparam int COMMAND_BLOCKS = 16;

  localparam int CMD_END = (COMMAND_BLOCKS < TOTAL_BLOCKS) ? COMMAND_BLOCKS : TOTAL_BLOCKS;
  localparam int WORDS   = (TOTAL_BLOCKS + 3) / 4;
  localparam int WA_W    = $clog2(WORDS);
  localparam int IDX_W   = $clog2(TOTAL_BLOCKS);

  localparam int CMD_FIRST_WORD  = 0;
  localparam int CMD_LAST_WORD   = (CMD_END - 1) / 4;
  localparam bit DATA_EMPTY      = (CMD_END >= TOTAL_BLOCKS);
  localparam int DATA_FIRST_WORD = DATA_EMPTY ? (WORDS - 1) : (CMD_END / 4);
  localparam int DATA_LAST_WORD  = WORDS - 1;

  localparam int FIELD_IDX_W = 6;
  localparam int ADDR_W      = 64;
  localparam int COUNT_W     = 8;
  localparam int WORD_W      = 4 * COUNT_W;

  localparam logic [WORD_W-1:0]  SIGN_MARKS = 32'h8080_8080;
  localparam logic [COUNT_W-1:0] COUNT_FREE = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 8'h01;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_DISPOSE  = 2'd1,
    OP_TRY_FREE = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] lane_en;
    logic [1:0] lane_sel;
  } scan_ctrl_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         hit_lane;
    logic [COUNT_W-1:0] new_cnt;
    logic               freed;
    logic [WORD_W-1:0]  word_new;
  } scan_res_t;

endpackage

[rtl/rba_if.sv]
interface rba_in_if import rba_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic                   from_command_region;
  logic [FIELD_IDX_W-1:0] block_index;
  logic [ADDR_W-1:0]      block_address;

  modport source (output valid, op, from_command_region, block_index, block_address,
                  input ready);
  modport sink (input valid, op, from_command_region, block_index, block_address,
                output ready);
endinterface

interface rba_out_if import rba_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FIELD_IDX_W-1:0]    granted_index;
  logic                      out_of_blocks;
  logic                      freed;
  logic [ADDR_W-1:0]         stored_address;
  logic signed [COUNT_W-1:0] usage_count;

  modport source (output valid, granted_index, out_of_blocks, freed, stored_address,
                  usage_count, input ready);
  modport sink (input valid, granted_index, out_of_blocks, freed, stored_address,
                usage_count, output ready);
endinterface

[rtl/rba_ram.sv]
module rba_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rba_scan_unit.sv]
module rba_scan_unit import rba_pkg::*; (
  input  scan_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] word,
  output scan_res_t         res
);

  logic [WORD_W-1:0]  marks;
  logic [3:0]         free_lane;
  logic [1:0]         sel;
  logic [COUNT_W-1:0] old_cnt;
  logic               in_use;

  assign marks = word & SIGN_MARKS;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      free_lane[j] = (|marks[COUNT_W*j +: COUNT_W]) & ctrl.lane_en[j];
    end
  end

  always_comb begin
    res = '0;
    res.hit = |free_lane;
    // lowest free lane wins
    if (free_lane[0]) begin
      res.hit_lane = 2'd0;
    end else if (free_lane[1]) begin
      res.hit_lane = 2'd1;
    end else if (free_lane[2]) begin
      res.hit_lane = 2'd2;
    end else begin
      res.hit_lane = 2'd3;
    end

    sel     = (ctrl.op == OP_ALLOC) ? res.hit_lane : ctrl.lane_sel;
    old_cnt = word[COUNT_W*sel +: COUNT_W];
    in_use  = (old_cnt != '0) && !old_cnt[COUNT_W-1];

    unique case (ctrl.op)
      OP_ALLOC:    res.new_cnt = COUNT_ONE;
      OP_DISPOSE:  res.new_cnt = old_cnt - COUNT_ONE;
      OP_TRY_FREE: res.new_cnt = in_use ? old_cnt : COUNT_FREE;
      OP_READ:     res.new_cnt = old_cnt;
      default:     res.new_cnt = old_cnt;
    endcase

    res.freed = (ctrl.op == OP_TRY_FREE) && !in_use;
    res.word_new = word;
    res.word_new[COUNT_W*sel +: COUNT_W] = res.new_cnt;
  end

endmodule

[rtl/rba_seq.sv]
`include "refcounted_block_allocator_core_macros.svh"

module rba_seq import rba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rba_in_if.sink            req,
  rba_out_if.source         rsp,
  output scan_ctrl_t        scan_ctrl,
  input  scan_res_t         scan_res,
  output logic              cnt_we,
  output logic [WA_W-1:0]   cnt_waddr,
  output logic [WORD_W-1:0] cnt_wdata,
  output logic [WA_W-1:0]   cnt_raddr,
  input  logic [WORD_W-1:0] cnt_rdata,
  output logic [WORD_W-1:0] scan_word,
  output logic              adr_we,
  output logic [IDX_W-1:0]  adr_waddr,
  output logic [ADDR_W-1:0] adr_wdata,
  output logic [IDX_W-1:0]  adr_raddr,
  input  logic [ADDR_W-1:0] adr_rdata
);

  state_t state, state_next;

  op_t               op;
  logic              region;
  logic              idx_ok;
  logic [1:0]        lane_sel;
  logic [WA_W-1:0]   word, word_next;
  logic [WA_W-1:0]   last_word;
  logic [IDX_W-1:0]  ent, ent_next;
  logic [ADDR_W-1:0] addr;

  logic [WORDS-1:0]        cnt_vld;
  logic [TOTAL_BLOCKS-1:0] adr_vld;

  logic                   res_oob, res_oob_next;
  logic                   res_freed, res_freed_next;
  logic [FIELD_IDX_W-1:0] res_granted, res_granted_next;
  logic [ADDR_W-1:0]      res_addr, res_addr_next;
  logic [COUNT_W-1:0]     res_count, res_count_next;

  logic       accept;
  logic       scan_done;
  logic       out_load;
  logic [3:0] region_mask;
  logic       out_valid;
  logic [ADDR_W-1:0] adr_eff;

  int lo_i, hi_i;

  assign accept = req.valid && req.ready;

  // lanes of the current word that fall inside the region being searched
  always_comb begin
    lo_i = region ? 0 : CMD_END;
    hi_i = region ? CMD_END : TOTAL_BLOCKS;
    for (int j = 0; j < 4; j++) begin
      region_mask[j] = (int'({word, 2'(j)}) >= lo_i) && (int'({word, 2'(j)}) < hi_i);
    end
  end

  assign last_word = region ? WA_W'(CMD_LAST_WORD) : WA_W'(DATA_LAST_WORD);
  // never-written rows read as their reset value
  assign scan_word = cnt_vld[word] ? cnt_rdata : {WORD_W{1'b1}};
  assign adr_eff   = adr_vld[ent] ? adr_rdata : '0;

  assign scan_ctrl.op       = op;
  assign scan_ctrl.lane_en  = (op == OP_ALLOC) ? region_mask : (4'b0001 << lane_sel);
  assign scan_ctrl.lane_sel = lane_sel;

  assign scan_done = (op != OP_ALLOC) || scan_res.hit || (word == last_word);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) state_next = S_SCAN;
      S_SCAN: if (scan_done) state_next = S_DONE;
      S_DONE: if (!out_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready        = (state == S_IDLE);
    word_next        = word;
    ent_next         = ent;
    cnt_we           = 1'b0;
    adr_we           = 1'b0;
    out_load         = 1'b0;
    res_oob_next     = res_oob;
    res_freed_next   = res_freed;
    res_granted_next = res_granted;
    res_addr_next    = res_addr;
    res_count_next   = res_count;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          ent_next = IDX_W'(req.block_index);
          if (op_t'(req.op) == OP_ALLOC) begin
            word_next = req.from_command_region ? WA_W'(CMD_FIRST_WORD)
                                                : WA_W'(DATA_FIRST_WORD);
          end else begin
            word_next = WA_W'(req.block_index >> 2);
          end
        end
      end
      S_SCAN: begin
        res_oob_next     = 1'b0;
        res_freed_next   = 1'b0;
        res_granted_next = '0;
        res_addr_next    = '0;
        res_count_next   = '0;
        if (op == OP_ALLOC) begin
          if (scan_res.hit) begin
            cnt_we           = 1'b1;
            adr_we           = 1'b1;
            res_granted_next = FIELD_IDX_W'({word, scan_res.hit_lane});
            res_count_next   = COUNT_ONE;
          end else if (word == last_word) begin
            res_oob_next = 1'b1;
          end else begin
            word_next = word + WA_W'(1);
          end
        end else if (idx_ok) begin
          cnt_we         = (op == OP_DISPOSE) || (op == OP_TRY_FREE && scan_res.freed);
          res_freed_next = scan_res.freed;
          res_addr_next  = (op == OP_READ) ? adr_eff : '0;
          res_count_next = scan_res.new_cnt;
        end
      end
      S_DONE: begin
        out_load = !out_valid || rsp.ready;
      end
      default: ;
    endcase
  end

  assign cnt_raddr = word_next;
  assign cnt_waddr = word;
  assign cnt_wdata = scan_res.word_new;
  assign adr_raddr = ent_next;
  assign adr_waddr = IDX_W'({word, scan_res.hit_lane});
  assign adr_wdata = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_vld   <= '0;
      adr_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_we) begin
        cnt_vld[word] <= 1'b1;
      end
      if (adr_we) begin
        adr_vld[adr_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word        <= word_next;
    ent         <= ent_next;
    res_oob     <= res_oob_next;
    res_freed   <= res_freed_next;
    res_granted <= res_granted_next;
    res_addr    <= res_addr_next;
    res_count   <= res_count_next;
    if (accept) begin
      op       <= op_t'(req.op);
      region   <= req.from_command_region;
      idx_ok   <= (TOTAL_BLOCKS >= 64) || (int'(req.block_index) < TOTAL_BLOCKS);
      lane_sel <= req.block_index[1:0];
      addr     <= req.block_address;
    end
    if (out_load) begin
      rsp.granted_index  <= res_granted;
      rsp.out_of_blocks  <= res_oob;
      rsp.freed          <= res_freed;
      rsp.stored_address <= res_addr;
      rsp.usage_count    <= res_count;
    end
  end

  assign rsp.valid = out_valid;

  `RBA_ASSERT_IMP(a_oob_clean, clk, rst, rsp.valid && rsp.out_of_blocks, rsp.usage_count == 0 && rsp.granted_index == 0 && !rsp.freed)
  `RBA_ASSERT_NEXT(a_write_ends_scan, clk, rst, cnt_we, state == S_DONE)
  `RBA_ASSERT_NEXT(a_single_word_ops, clk, rst, state == S_SCAN && op != OP_ALLOC, state == S_DONE)
  `RBA_ASSERT_IMP(a_scan_in_region, clk, rst, state == S_SCAN && op == OP_ALLOC, word <= last_word)

endmodule

[rtl/refcounted_block_allocator_core.sv]
// Dispose, try free and read each work on the one count word that holds their entry.
// Allocate checks four counts per cycle from the count RAM's single read port,
// one region word after another (1 to 12 region words scanned in the data region).
// A new item is taken only in idle, once the last result is in the output register; a finished
// result waits in the output register while the next item is taken.
// Reset: synchronous; all entries read as free with address zero right after reset.
module refcounted_block_allocator_core import rba_pkg::*; (
  input logic       clk,
  input logic       rst,
  rba_in_if.sink    req,
  rba_out_if.source rsp
);

  scan_ctrl_t        scan_ctrl;
  scan_res_t         scan_res;
  logic [WORD_W-1:0] scan_word;

  logic              cnt_we;
  logic [WA_W-1:0]   cnt_waddr, cnt_raddr;
  logic [WORD_W-1:0] cnt_wdata, cnt_rdata;

  logic              adr_we;
  logic [IDX_W-1:0]  adr_waddr, adr_raddr;
  logic [ADDR_W-1:0] adr_wdata, adr_rdata;

  rba_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .scan_ctrl (scan_ctrl),
    .scan_res  (scan_res),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_raddr (cnt_raddr),
    .cnt_rdata (cnt_rdata),
    .scan_word (scan_word),
    .adr_we    (adr_we),
    .adr_waddr (adr_waddr),
    .adr_wdata (adr_wdata),
    .adr_raddr (adr_raddr),
    .adr_rdata (adr_rdata)
  );

  rba_scan_unit u_scan (
    .ctrl (scan_ctrl),
    .word (scan_word),
    .res  (scan_res)
  );

  // four usage counts per word
  rba_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_W)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  rba_ram #(
    .DEPTH (TOTAL_BLOCKS),
    .WIDTH (ADDR_W)
  ) u_adr_ram (
    .clk   (clk),
    .we    (adr_we),
    .waddr (adr_waddr),
    .wdata (adr_wdata),
    .raddr (adr_raddr),
    .rdata (adr_rdata)
  );

endmodule

[tb/sv/rba_table_checker.sv]
`timescale 1ns / 1ps
module rba_table_checker import rba_pkg::*; (
  input  logic clk,
  input  logic rst,
  rba_in_if    req_mon,
  rba_out_if   rsp_mon,
  output int   fail_count,
  output int   pending,
  output int   full_hits
);

  typedef struct packed {
    logic [FIELD_IDX_W-1:0]    granted_index;
    logic                      out_of_blocks;
    logic                      freed;
    logic [ADDR_W-1:0]         stored_address;
    logic signed [COUNT_W-1:0] usage_count;
  } alloc_result_t;

  logic [COUNT_W-1:0] use_count [TOTAL_BLOCKS];
  logic [ADDR_W-1:0]  held_addr [TOTAL_BLOCKS];
  alloc_result_t      awaited_q [$];

  // Updates the block table for one item and returns the answer it should give.
  function automatic alloc_result_t apply_request(op_t op, logic cmd,
                                                  logic [FIELD_IDX_W-1:0] idx,
                                                  logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    int lo;
    int hi;
    int hit;
    r = '0;
    if (op == OP_ALLOC) begin
      lo  = cmd ? 0 : CMD_END;
      hi  = cmd ? CMD_END : TOTAL_BLOCKS;
      hit = hi;
      // lowest entry with the sign bit set wins
      for (int i = hi - 1; i >= lo; i--) begin
        if (use_count[i][COUNT_W-1]) hit = i;
      end
      if (hit < hi) begin
        held_addr[hit]  = addr;
        use_count[hit]  = COUNT_ONE;
        r.granted_index = FIELD_IDX_W'(hit);
        r.usage_count   = COUNT_ONE;
      end else begin
        r.out_of_blocks = 1'b1;
        full_hits++;
      end
    end else if (int'(idx) < TOTAL_BLOCKS) begin
      case (op)
        OP_DISPOSE: begin
          use_count[idx] = use_count[idx] - 8'd1;
        end
        OP_TRY_FREE: begin
          if (use_count[idx] != '0 && !use_count[idx][COUNT_W-1]) begin
            r.freed = 1'b0;
          end else begin
            use_count[idx] = COUNT_FREE;
            r.freed        = 1'b1;
          end
        end
        default: begin
          r.stored_address = held_addr[idx];
        end
      endcase
      r.usage_count = use_count[idx];
    end
    return r;
  endfunction

  task automatic flag_field(string name, logic [ADDR_W-1:0] exp, logic [ADDR_W-1:0] act);
    if (exp !== act) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      for (int i = 0; i < TOTAL_BLOCKS; i++) begin
        use_count[i] = COUNT_FREE;
        held_addr[i] = '0;
      end
      awaited_q.delete();
      fail_count = 0;
      full_hits  = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        awaited_q.push_back(apply_request(op_t'(req_mon.op), req_mon.from_command_region,
                                          req_mon.block_index, req_mon.block_address));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, got index %0d oob %0b freed %0b addr %h count %0d",
                   $time, rsp_mon.granted_index, rsp_mon.out_of_blocks, rsp_mon.freed,
                   rsp_mon.stored_address, rsp_mon.usage_count);
        end else begin
          want = awaited_q.pop_front();
          flag_field("granted_index", want.granted_index, rsp_mon.granted_index);
          flag_field("out_of_blocks", want.out_of_blocks, rsp_mon.out_of_blocks);
          flag_field("freed", want.freed, rsp_mon.freed);
          flag_field("stored_address", want.stored_address, rsp_mon.stored_address);
          flag_field("usage_count", want.usage_count, rsp_mon.usage_count);
        end
      end
    end
    pending = awaited_q.size();
  end

endmodule

[tb/sv/refcounted_block_allocator_core_tb.sv]
`timescale 1ns / 1ps
module refcounted_block_allocator_core_tb;
  import rba_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   full_hits;
  int   op_sent [4];
  int   quiet;
  bit   steady;
  bit   hold_req;

  rba_in_if  req_ch ();
  rba_out_if rsp_ch ();

  refcounted_block_allocator_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  rba_table_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .full_hits  (full_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 29);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_address();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(op_t op, logic cmd, logic [FIELD_IDX_W-1:0] idx,
                           logic [ADDR_W-1:0] addr);
    while (take_gap()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid               <= 1'b1;
    req_ch.op                  <= op;
    req_ch.from_command_region <= cmd;
    req_ch.block_index         <= idx;
    req_ch.block_address       <= addr;
    op_sent[int'(op)]++;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // result side
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          rsp_ch.ready <= 1'b0;
          @(negedge clk);
        end
      end
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int               mode;
    int               pick;
    op_t              op;
    logic [FIELD_IDX_W-1:0] idx;
    rst                        = 1'b1;
    steady                     = 1'b0;
    hold_req                   = 1'b0;
    quiet                      = 0;
    mode                       = 0;
    req_ch.valid               = 1'b0;
    req_ch.op                  = OP_ALLOC;
    req_ch.from_command_region = 1'b0;
    req_ch.block_index         = '0;
    req_ch.block_address       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset contents, grants in both regions, free and wrap corners
    send_item(OP_READ, 1'b0, 6'd0, '0);
    send_item(OP_READ, 1'b1, 6'd63, '1);
    send_item(OP_ALLOC, 1'b1, 6'd63, '1);
    send_item(OP_ALLOC, 1'b0, 6'd0, '0);
    send_item(OP_ALLOC, 1'b0, 6'd21, 64'h8000_0000_0000_0001);
    send_item(OP_READ, 1'b0, 6'd0, '0);
    send_item(OP_READ, 1'b0, 6'd16, '0);
    send_item(OP_READ, 1'b0, 6'd17, '0);
    send_item(OP_TRY_FREE, 1'b0, 6'd0, '0);   // still in use
    send_item(OP_DISPOSE, 1'b0, 6'd0, '0);
    send_item(OP_TRY_FREE, 1'b0, 6'd0, '0);   // count zero releases it
    send_item(OP_TRY_FREE, 1'b0, 6'd0, '0);   // already free
    send_item(OP_DISPOSE, 1'b0, 6'd63, '0);   // dispose on a free entry
    send_item(OP_TRY_FREE, 1'b1, 6'd63, '0);
    send_item(OP_DISPOSE, 1'b0, 6'd16, '0);
    send_item(OP_DISPOSE, 1'b0, 6'd16, '0);
    send_item(OP_ALLOC, 1'b0, 6'd0, 64'h0123_4567_89ab_cdef);   // reuses 16
    send_item(OP_READ, 1'b0, 6'd16, '0);
    send_item(OP_READ, 1'b0, 6'd42, '0);

    // fill each region and go past its end
    for (int i = 0; i <= CMD_END; i++) send_item(OP_ALLOC, 1'b1, 6'($urandom), rand_address());
    for (int i = CMD_END; i <= TOTAL_BLOCKS; i++) begin
      send_item(OP_ALLOC, 1'b0, 6'($urandom), rand_address());
    end

    // walk one count from 1 down through -128 so it wraps to +127
    for (int i = 0; i < 130; i++) send_item(OP_DISPOSE, 1'b0, 6'd40, '0);
    send_item(OP_READ, 1'b0, 6'd40, '0);
    send_item(OP_TRY_FREE, 1'b0, 6'd40, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      if (n == 300) hold_req = 1'b1;
      steady = (n >= 800 && n < 1000);
      pick   = $urandom_range(0, 99);
      case (mode)
        0: op = (pick < 60) ? OP_ALLOC : (pick < 75) ? OP_DISPOSE :
                (pick < 90) ? OP_TRY_FREE : OP_READ;
        1: op = (pick < 10) ? OP_ALLOC : (pick < 50) ? OP_DISPOSE :
                (pick < 90) ? OP_TRY_FREE : OP_READ;
        default: op = op_t'(pick[1:0]);
      endcase
      // low entries are the ones most likely to be in use
      idx = $urandom_range(0, 1) ? 6'($urandom_range(0, 23)) : 6'($urandom);
      send_item(op, 1'($urandom), idx, rand_address());
    end
    req_ch.valid <= 1'b0;
    steady = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d allocations (%0d into a full region), %0d disposes,",
             op_sent[int'(OP_ALLOC)], full_hits, op_sent[int'(OP_DISPOSE)]);
    $display("  %0d try-frees and %0d reads, with random stalls and a long output hold",
             op_sent[int'(OP_TRY_FREE)], op_sent[int'(OP_READ)]);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
